### hdl/cisf_pkg.sv
// Shared types, constants and helpers for the case-insensitive substring finder.
package cisf_pkg;

  // Default values of the top-level parameters.
  localparam int MAX_PATTERN_DEF   = 16;
  localparam int POSITION_BITS_DEF = 32;

  // Number of pattern bytes that the two pattern registers can hold.
  localparam int PAT_BYTES = 16;

  // Configuration register indexes (byte address is eight times the index).
  localparam logic [1:0] REG_PAT_LO  = 2'd0;
  localparam logic [1:0] REG_PAT_HI  = 2'd1;
  localparam logic [1:0] REG_PAT_LEN = 2'd2;

  // Control group from the top level to the window.
  typedef struct packed {
    logic shift;  // shift the current byte into the window
    logic clear;  // end of text: empty the window fill count
  } cisf_win_ctl_t;

  // Fold ASCII upper-case letters to lower case; all other bytes pass unchanged.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c inside {[8'h41:8'h5A]}) begin
      return c + 8'h20;
    end
    return c;
  endfunction

endpackage

### hdl/cisf_window.sv
// Window of recent text bytes and the parallel compare against the pattern.
module cisf_window #(
  parameter int MAX_PATTERN = cisf_pkg::MAX_PATTERN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cisf_pkg::cisf_win_ctl_t            ctl,
  input  logic [7:0]                         text_byte,
  input  logic [63:0]                        pat_lo,
  input  logic [63:0]                        pat_hi,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]   len,
  output logic                               hit
);
  import cisf_pkg::*;

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);

  logic [7:0]       recent_r [MAX_PATTERN];
  logic [7:0]       win_nxt  [MAX_PATTERN];
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;
  logic [127:0]     pat_all;
  logic [7:0]       pat_arr  [PAT_BYTES];
  logic [CNT_W-1:0] pidx;
  logic [7:0]       pbyte;
  logic             bytes_eq;

  // Unpack the pattern registers into bytes, byte 0 first.
  assign pat_all = {pat_hi, pat_lo};
  always_comb begin
    for (int k = 0; k < PAT_BYTES; k++) begin
      pat_arr[k] = pat_all[8*k +: 8];
    end
  end

  // Window after this byte: the new folded byte enters at the newest end.
  always_comb begin
    win_nxt[0] = fold_case(text_byte);
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win_nxt[j] = recent_r[j-1];
    end
  end

  // Fill count saturates at the window depth.
  always_comb begin
    if (32'(fill_r) == MAX_PATTERN) begin
      fill_nxt = fill_r;
    end else begin
      fill_nxt = fill_r + CNT_W'(1);
    end
  end

  // Window byte j pairs with pattern byte len-1-j; bytes past the length are ignored.
  always_comb begin
    bytes_eq = 1'b1;
    pidx     = '0;
    pbyte    = 8'h00;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pidx  = len - CNT_W'(j) - CNT_W'(1);
      pbyte = 8'h00;
      if (32'(pidx) < PAT_BYTES) begin
        pbyte = pat_arr[4'(pidx)];
      end
      if ((CNT_W'(j) < len) && (win_nxt[j] != fold_case(pbyte))) begin
        bytes_eq = 1'b0;
      end
    end
  end

  assign hit = (len != '0) && (fill_nxt >= len) && bytes_eq;

  // Window shift line and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
        recent_r[j] <= 8'h00;
      end
    end else if (ctl.shift) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        recent_r[j] <= win_nxt[j];
      end
      fill_r <= ctl.clear ? '0 : fill_nxt;
    end
  end

endmodule

### hdl/case_insensitive_substring_finder_unit.sv
// Top level: stream ports, register file, match position tracking and result stage.
// A byte accepted into the input register moves to the result register when that is empty or draining.
// Throughput: one byte per cycle while out_tready does not hold the result; the input and
// result registers form an elastic two-stage pipeline, so a byte is taken while a finished
// result still waits. Reset (rst_n low, synchronous) empties both stages, clears the pattern
// registers, the window, the position, the skip point and the match count.
module case_insensitive_substring_finder_unit #(
  parameter int MAX_PATTERN   = cisf_pkg::MAX_PATTERN_DEF,
  parameter int POSITION_BITS = cisf_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Text input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_text
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] match_start, [63:32] match_total
  output logic        out_tuser,  // match_found
  output logic        out_tlast,  // text_done
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import cisf_pkg::*;

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int PB    = POSITION_BITS;

  // Configuration registers.
  logic [63:0] pat_lo_r;
  logic [63:0] pat_hi_r;
  logic [4:0]  pat_len_r;
  logic        cfg_wr;

  // Input stage.
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        s1_adv;
  logic        work;

  // Text state.
  logic [PB-1:0] pos_r;
  logic [PB-1:0] ens_r;
  logic [31:0]   cnt_r;

  // Compute path.
  logic [CNT_W-1:0] len_eff;
  logic             win_hit;
  cisf_win_ctl_t    win_ctl;
  logic [PB-1:0]    pos1;
  logic [PB-1:0]    gap;
  logic             found;
  logic [PB-1:0]    start_full;
  logic [63:0]      start_ext;
  logic [31:0]      cnt_nxt;

  // Result stage.
  logic        out_valid_r;
  logic        match_found_r;
  logic [31:0] match_start_r;
  logic [31:0] match_total_r;
  logic        text_done_r;

  // Register writes and reads.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      pat_len_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:3])
        REG_PAT_LO:  pat_lo_r  <= cfg_pwdata;
        REG_PAT_HI:  pat_hi_r  <= cfg_pwdata;
        REG_PAT_LEN: pat_len_r <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:3])
      REG_PAT_LO:  cfg_prdata = pat_lo_r;
      REG_PAT_HI:  cfg_prdata = pat_hi_r;
      REG_PAT_LEN: cfg_prdata = {59'd0, pat_len_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // Handshake: each stage moves on when the one after it is empty or draining.
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign work      = s1_valid_r && s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // Pattern lengths beyond the window depth are taken as the depth.
  always_comb begin
    if (32'(pat_len_r) > MAX_PATTERN) begin
      len_eff = CNT_W'(MAX_PATTERN);
    end else begin
      len_eff = CNT_W'(pat_len_r);
    end
  end

  assign win_ctl.shift = work;
  assign win_ctl.clear = s1_last_r;

  cisf_window #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (win_ctl),
    .text_byte (s1_byte_r),
    .pat_lo    (pat_lo_r),
    .pat_hi    (pat_hi_r),
    .len       (len_eff),
    .hit       (win_hit)
  );

  // A match counts only if it starts at or after the end of the previous one.
  assign pos1       = pos_r + PB'(1);
  assign gap        = pos1 - ens_r;
  assign found      = win_hit && (gap >= PB'(len_eff));
  assign start_full = found ? (pos1 - PB'(len_eff)) : '0;
  assign start_ext  = 64'(start_full);
  assign cnt_nxt    = (found && (cnt_r != 32'hFFFF_FFFF)) ? cnt_r + 32'd1 : cnt_r;

  // Text state: position, skip point and count, cleared after the last byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ens_r <= '0;
      cnt_r <= '0;
    end else if (work) begin
      if (s1_last_r) begin
        pos_r <= '0;
        ens_r <= '0;
        cnt_r <= '0;
      end else begin
        pos_r <= pos1;
        if (found) begin
          ens_r <= pos1;
        end
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      match_found_r <= found;
      match_start_r <= start_ext[31:0];
      match_total_r <= cnt_nxt;
      text_done_r   <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {match_total_r, match_start_r};
  assign out_tuser  = match_found_r;
  assign out_tlast  = text_done_r;

  // A reported match is always included in the count.
  a_found_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && match_found_r) |-> (match_total_r != 32'd0))
    else $error("match reported with a zero match count");

  // Without a match the start field reads zero.
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !match_found_r) |-> (match_start_r == 32'd0))
    else $error("match start nonzero without a match");

  // After the last byte of a text the next text starts from a clean state.
  a_text_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (work && s1_last_r) |=> ((pos_r == '0) && (ens_r == '0) && (cnt_r == 32'd0)))
    else $error("text state not cleared after end of text");

  // After a match the skip point is the next byte position.
  a_skip_point: assert property (@(posedge clk) disable iff (!rst_n)
    (work && found) |=> (ens_r == pos_r))
    else $error("skip point does not follow the match");

endmodule

### test/substring_match_checker.sv
// Checker for the substring finder: watches all three ports, predicts each result and compares.
module substring_match_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_text
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,  // [31:0] match_start, [63:32] match_total
  input  logic        out_tuser,  // match_found
  input  logic        out_tlast,  // text_done
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import cisf_pkg::*;

  localparam int WINDOW = MAX_PATTERN_DEF;

  typedef struct packed {
    logic        found;
    logic [31:0] start;
    logic [31:0] total;
    logic        done;
  } scan_result_t;

  // Shadow copy of the pattern registers.
  logic [63:0] pattern_lo;
  logic [63:0] pattern_hi;
  logic [4:0]  pattern_len;

  // Search state of the current text.
  logic [7:0]  window [WINDOW];
  int          window_fill;
  logic [31:0] position;
  logic [31:0] resume_at;
  logic [31:0] match_count;

  scan_result_t expected_results[$];
  scan_result_t seen;
  scan_result_t want;

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic logic [7:0] pattern_char(input int i);
    return (i < 8) ? pattern_lo[8*i +: 8] : pattern_hi[8*(i-8) +: 8];
  endfunction

  // Advance the search by one text byte and return the result it must produce.
  function automatic scan_result_t scan_byte(input logic [7:0] raw, input logic last);
    scan_result_t r;
    logic [31:0]  span;
    int           len;
    r = '0;
    for (int i = WINDOW - 1; i > 0; i--) begin
      window[i] = window[i-1];
    end
    window[0] = lower(raw);
    if (window_fill < WINDOW) begin
      window_fill++;
    end
    len = (pattern_len > WINDOW) ? WINDOW : int'(pattern_len);
    // Bytes from the first allowed start up to and including this one.
    span = position + 32'd1 - resume_at;
    r.found = (len > 0 && window_fill >= len && span >= 32'(len));
    for (int i = 0; i < len; i++) begin
      if (window[len-1-i] != lower(pattern_char(i))) begin
        r.found = 1'b0;
      end
    end
    if (r.found) begin
      r.start = position + 32'd1 - 32'(len);
      resume_at = position + 32'd1;
      if (match_count != '1) begin
        match_count++;
      end
    end
    r.total = match_count;
    r.done = last;
    // The end of a text restarts position, skip point, count and window fill.
    if (last) begin
      position = '0;
      resume_at = '0;
      match_count = '0;
      window_fill = 0;
    end else begin
      position++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pattern_lo = '0;
      pattern_hi = '0;
      pattern_len = '0;
      foreach (window[i]) begin
        window[i] = '0;
      end
      window_fill = 0;
      position = '0;
      resume_at = '0;
      match_count = '0;
      mismatches = 0;
      expected_results.delete();
    end else begin
      // A result transaction is matched against the oldest prediction.
      if (out_tvalid && out_tready) begin
        seen = {out_tuser, out_tdata[31:0], out_tdata[63:32], out_tlast};
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: found=%b start=%0d total=%0d done=%b",
                   $time, seen.found, seen.start, seen.total, seen.done);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            $display("%0t: expected found=%b start=%0d total=%0d done=%b", $time,
                     want.found, want.start, want.total, want.done);
            $display("%0t:   actual found=%b start=%0d total=%0d done=%b", $time,
                     seen.found, seen.start, seen.total, seen.done);
            mismatches++;
          end
        end
      end
      // Register writes take effect on the next text byte.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[2:0] == 3'b000) begin
        case (cfg_paddr[4:3])
          REG_PAT_LO:  pattern_lo = cfg_pwdata;
          REG_PAT_HI:  pattern_hi = cfg_pwdata;
          REG_PAT_LEN: pattern_len = cfg_pwdata[4:0];
          default: ;
        endcase
      end
      // Every accepted text byte yields exactly one result, queued behind the older ones.
      if (in_tvalid && in_tready) begin
        expected_results.insert(expected_results.size(), scan_byte(in_tdata, in_tlast));
      end
    end
    outstanding = expected_results.size();
  end

endmodule

### test/testbench.sv
// Top of the substring finder testbench: clock, reset, text stimulus, stalls and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cisf_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 200;
  localparam int RANDOM_ITEMS = 600;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] text_byte
  logic        in_tlast;   // end_of_text
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [31:0] match_start, [63:32] match_total
  logic        out_tuser;  // match_found
  logic        out_tlast;  // text_done
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  int mismatches;
  int outstanding;
  int send_pace;
  int recv_pace;
  bit hold_request;
  int random_sent;
  int cycle_count;

  // Pattern as last loaded, used to plant matches in the text.
  logic [7:0] pat_chars [16];
  int         pat_used;

  case_insensitive_substring_finder_unit u_top (.*);

  substring_match_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit, counted in clock cycles.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random stalls per transaction, and one long hold-off on request.
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = $urandom_range(0, recv_pace);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {index, 3'b000};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every predicted result has come out, then let the pipeline settle.
  task automatic drain_results();
    wait (outstanding == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] len);
    in_tvalid <= 1'b0;
    drain_results();
    write_reg(REG_PAT_LO, lo);
    write_reg(REG_PAT_HI, hi);
    write_reg(REG_PAT_LEN, 64'(len));
    for (int i = 0; i < 8; i++) begin
      pat_chars[i] = lo[8*i +: 8];
      pat_chars[i+8] = hi[8*i +: 8];
    end
    pat_used = (len > 16) ? 16 : int'(len);
  endtask

  task automatic send_byte(input logic [7:0] c, input logic last);
    int gap;
    gap = $urandom_range(0, send_pace);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_string(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], close && i == s.len() - 1);
    end
  endtask

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  // Half the time a, b or c in either case; else bytes around the letter ranges, high bytes or any byte.
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: begin
        c = 8'h61 + 8'($urandom_range(0, 2));
        if ($urandom_range(0, 1) == 1) begin
          c = flip_case(c);
        end
      end
      4: begin
        case ($urandom_range(0, 3))
          0: c = 8'h40;
          1: c = 8'h5B;
          2: c = 8'h60;
          default: c = 8'h7B;
        endcase
      end
      5: c = 8'($urandom_range(128, 255));
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  task automatic random_pattern();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    int          r;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pick_char();
      hi[8*i +: 8] = pick_char();
    end
    case ($urandom_range(0, 9))
      0: begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
      end
      1: begin
        lo = '1;
        hi = '1;
      end
      2: begin
        lo = '0;
        hi = '0;
      end
      default: ;
    endcase
    r = $urandom_range(0, 9);
    if (r == 0) begin
      len = 5'd0;
    end else if (r == 1) begin
      len = 5'd16;
    end else if (r == 2) begin
      len = 5'($urandom_range(17, 31));
    end else begin
      len = 5'($urandom_range(1, 5));
    end
    load_pattern(lo, hi, len);
  endtask

  // One text of n bytes: planted pattern copies with random case, some broken, and noise.
  task automatic send_text(input int n, input logic close);
    int         k;
    int         bad;
    logic [7:0] c;
    k = 0;
    while (k < n) begin
      if (pat_used > 0 && k + pat_used <= n && $urandom_range(0, 2) == 0) begin
        bad = ($urandom_range(0, 5) == 0) ? $urandom_range(0, pat_used - 1) : -1;
        for (int j = 0; j < pat_used; j++) begin
          c = pat_chars[j];
          if ($urandom_range(0, 1) == 1) begin
            c = flip_case(c);
          end
          if (j == bad) begin
            c = c ^ (8'h01 << $urandom_range(0, 7));
          end
          send_byte(c, close && k == n - 1);
          k++;
        end
      end else begin
        send_byte(pick_char(), close && k == n - 1);
        k++;
      end
    end
    random_sent += n;
  endtask

  initial begin : stimulus
    int phase;
    int budget;
    int n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    hold_request = 1'b0;
    send_pace = 7;
    recv_pace = 7;
    pat_used = 0;
    random_sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty pattern after reset: even zero bytes must not match.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Letters fold in both the pattern and the text.
    load_pattern(64'h6241, 64'h0, 5'd2);
    send_string("xAbaB", 1'b1);
    // Overlapping candidates: only the leftmost counts.
    load_pattern(64'h6161, 64'h0, 5'd2);
    send_string("aaa", 1'b1);
    // Neighbors of the letter ranges and high bytes compare exactly.
    load_pattern(64'hC15B40, 64'h0, 5'd3);
    send_byte(8'h60, 1'b0);
    send_byte(8'h7B, 1'b0);
    send_byte(8'hE1, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h5B, 1'b0);
    send_byte(8'hC1, 1'b1);
    // Overlong length acts as 16 bytes; the text stays open across a register change.
    load_pattern({8{8'h5A}}, {8{8'h5A}}, 5'd31);
    repeat (16) send_byte(8'h7A, 1'b0);
    load_pattern(64'h7A, 64'h0, 5'd1);
    send_byte(8'h5A, 1'b1);

    // Random phases, each under a fresh pattern and pacing.
    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      random_pattern();
      send_pace = ($urandom_range(0, 2) == 0) ? 0 : 7;
      recv_pace = ($urandom_range(0, 2) == 0) ? 0 : 7;
      if (phase == 3) begin
        send_pace = 0;
        hold_request = 1'b1;
      end
      budget = $urandom_range(30, 80);
      while (budget > 0) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
        if (n > budget) begin
          n = budget;
        end
        budget -= n;
        // The last text of a phase is sometimes left open over the next register writes.
        send_text(n, budget > 0 || $urandom_range(0, 3) != 0);
      end
      phase++;
    end

    in_tvalid <= 1'b0;
    drain_results();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hdl/cisf_pkg.sv
hdl/cisf_window.sv
hdl/case_insensitive_substring_finder_unit.sv
test/substring_match_checker.sv
test/testbench.sv
